// ----- rtl/sle_pkg.sv -----
// Package for the sequential list engine.
// Holds the field widths, command and status codes, sequencer states and
// the result word type. It depends on nothing else.
package sle_pkg;

  localparam int CMD_W        = 2;
  localparam int WORD_W       = 32;
  localparam int CNT_W        = 7;
  localparam int STAT_W       = 2;
  localparam int DEF_CAPACITY = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND,
    CMD_DELETE,
    CMD_DEDUPE,
    CMD_SPLIT
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK,
    STAT_EMPTY,
    STAT_BADPOS,
    STAT_FULL
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DD_RD,
    ST_DD_CAP,
    ST_DD_CMP_RD,
    ST_DD_CMP,
    ST_SP_RD,
    ST_SP_OUT
  } state_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] item;
    logic                     to_positive;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } result_t;

endpackage

// ----- rtl/sle_mem.sv -----
// Entry store of the sequential list engine: one write port and one read
// port with a registered read. Uses sle_pkg for the word width.
module sle_mem #(
  parameter int DEPTH = sle_pkg::DEF_CAPACITY,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [sle_pkg::WORD_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [sle_pkg::WORD_W-1:0] rdata
);
  import sle_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sle_ctrl.sv -----
// Command sequencer of the sequential list engine: holds the entry count,
// walks the entry store one access at a time and registers each result word.
// Uses sle_pkg and drives the ports of sle_mem.
module sle_ctrl #(
  parameter int CAPACITY = sle_pkg::DEF_CAPACITY,
  localparam int AW      = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  sle_pkg::cmd_t              cmd,
  input  logic [sle_pkg::WORD_W-1:0] value,
  input  logic [sle_pkg::CNT_W-1:0]  position,
  output logic                       busy,
  output logic                       strobe,
  output sle_pkg::result_t           res,
  output logic                       we,
  output logic [AW-1:0]              waddr,
  output logic [sle_pkg::WORD_W-1:0] wdata,
  output logic                       re,
  output logic [AW-1:0]              raddr,
  input  logic [sle_pkg::WORD_W-1:0] rdata
);
  import sle_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t            state, state_next;
  logic [CNT_W-1:0]  n, n_next;
  logic [CNT_W-1:0]  ptr, ptr_next;
  logic [CNT_W-1:0]  wp, wp_next;
  logic [CNT_W-1:0]  k, k_next;
  logic [WORD_W-1:0] cand, cand_next;
  logic              strobe_next;
  result_t           res_next;
  logic [CNT_W-1:0]  ptr_inc;

  assign ptr_inc = ptr + CNT_W'(1);
  assign busy    = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    n_next      = n;
    ptr_next    = ptr;
    wp_next     = wp;
    k_next      = k;
    cand_next   = cand;
    strobe_next = 1'b0;
    res_next    = res;
    we          = 1'b0;
    waddr       = ptr[AW-1:0];
    wdata       = value;
    re          = 1'b0;
    raddr       = ptr[AW-1:0];

    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_APPEND: begin
              strobe_next = 1'b1;
              if (n >= CAP_CNT) begin
                res_next = '{STAT_FULL, '0, 1'b0, n, 1'b1};
              end else begin
                we       = 1'b1;
                waddr    = n[AW-1:0];
                wdata    = value;
                n_next   = n + CNT_W'(1);
                res_next = '{STAT_OK, '0, 1'b0, n + CNT_W'(1), 1'b1};
              end
            end
            CMD_DELETE: begin
              if (n == '0) begin
                strobe_next = 1'b1;
                res_next    = '{STAT_EMPTY, '0, 1'b0, n, 1'b1};
              end else if (position == '0 || position > n) begin
                strobe_next = 1'b1;
                res_next    = '{STAT_BADPOS, '0, 1'b0, n, 1'b1};
              end else begin
                ptr_next   = position - CNT_W'(1);
                state_next = ST_DEL_RD;
              end
            end
            CMD_DEDUPE: begin
              ptr_next   = '0;
              wp_next    = '0;
              state_next = ST_DD_RD;
            end
            default: begin
              if (n == '0) begin
                strobe_next = 1'b1;
                res_next    = '{STAT_EMPTY, '0, 1'b0, n, 1'b1};
              end else begin
                ptr_next   = '0;
                state_next = ST_SP_RD;
              end
            end
          endcase
        end
      end
      ST_DEL_RD: begin
        if (ptr_inc == n) begin
          n_next      = n - CNT_W'(1);
          strobe_next = 1'b1;
          res_next    = '{STAT_OK, '0, 1'b0, n - CNT_W'(1), 1'b1};
          state_next  = ST_IDLE;
        end else begin
          re         = 1'b1;
          raddr      = ptr_inc[AW-1:0];
          state_next = ST_DEL_WR;
        end
      end
      ST_DEL_WR: begin
        we         = 1'b1;
        waddr      = ptr[AW-1:0];
        wdata      = rdata;
        ptr_next   = ptr_inc;
        state_next = ST_DEL_RD;
      end
      ST_DD_RD: begin
        if (ptr == n) begin
          n_next      = wp;
          strobe_next = 1'b1;
          res_next    = '{STAT_OK, '0, 1'b0, wp, 1'b1};
          state_next  = ST_IDLE;
        end else begin
          re         = 1'b1;
          raddr      = ptr[AW-1:0];
          state_next = ST_DD_CAP;
        end
      end
      ST_DD_CAP: begin
        cand_next  = rdata;
        k_next     = '0;
        state_next = ST_DD_CMP_RD;
      end
      ST_DD_CMP_RD: begin
        if (k == wp) begin
          we         = 1'b1;
          waddr      = wp[AW-1:0];
          wdata      = cand;
          wp_next    = wp + CNT_W'(1);
          ptr_next   = ptr_inc;
          state_next = ST_DD_RD;
        end else begin
          re         = 1'b1;
          raddr      = k[AW-1:0];
          state_next = ST_DD_CMP;
        end
      end
      ST_DD_CMP: begin
        if (rdata == cand) begin
          ptr_next   = ptr_inc;
          state_next = ST_DD_RD;
        end else begin
          k_next     = k + CNT_W'(1);
          state_next = ST_DD_CMP_RD;
        end
      end
      ST_SP_RD: begin
        re         = 1'b1;
        raddr      = ptr[AW-1:0];
        state_next = ST_SP_OUT;
      end
      ST_SP_OUT: begin
        strobe_next = 1'b1;
        res_next    = '{STAT_OK, rdata, ~rdata[WORD_W-1] && (rdata != '0), n,
                        ptr_inc == n};
        ptr_next    = ptr_inc;
        state_next  = (ptr_inc == n) ? ST_IDLE : ST_SP_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n      <= '0;
      strobe <= 1'b0;
    end else begin
      n      <= n_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    wp   <= wp_next;
    k    <= k_next;
    cand <= cand_next;
    res  <= res_next;
  end

endmodule

// ----- rtl/sequential_list_engine_top.sv -----
// Top level of the sequential list engine: sequencer plus entry store.
// Uses sle_pkg, sle_ctrl and sle_mem.
//
// A command is taken when start is high and busy is low; its result words
// appear on the cycle after the work ends, each for one cycle under strobe,
// and must be taken then, as the receiver cannot stall the block. Every
// entry read goes through the single read port of the entry store, whose
// read is registered, and that port sets the pace. Append and every
// rejected command finish in the idle state. Delete at position p moves
// each later entry down one place, a read then a write. Split reads each
// entry and gives one result word for it, the last marked by last. Dedupe
// reads each entry once, compares it with the survivors kept so far until
// one matches, and keeps it if none does. No clearing pass follows reset.
module sequential_list_engine_top #(
  parameter int CAPACITY = sle_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [sle_pkg::CMD_W-1:0]         cmd,
  input  logic signed [sle_pkg::WORD_W-1:0] value,
  input  logic [sle_pkg::CNT_W-1:0]         position,
  output logic                              strobe,
  output logic [sle_pkg::STAT_W-1:0]        status,
  output logic signed [sle_pkg::WORD_W-1:0] item,
  output logic                              to_positive,
  output logic [sle_pkg::CNT_W-1:0]         count,
  output logic                              last
);
  import sle_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  result_t           res;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;

  sle_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd_t'(cmd)),
    .value   (value),
    .position(position),
    .busy    (busy),
    .strobe  (strobe),
    .res     (res),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  sle_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign status      = res.status;
  assign item        = res.item;
  assign to_positive = res.to_positive;
  assign count       = res.count;
  assign last        = res.last;

endmodule

// ----- rtl/sle_checker.sv -----
// Port checker for the sequential list engine and its bind to the top level.
// Uses sle_pkg for widths and status codes.
module sle_port_checker #(
  parameter int CAPACITY = sle_pkg::DEF_CAPACITY
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic [sle_pkg::CMD_W-1:0]         cmd,
  input logic signed [sle_pkg::WORD_W-1:0] value,
  input logic [sle_pkg::CNT_W-1:0]         position,
  input logic                              strobe,
  input logic [sle_pkg::STAT_W-1:0]        status,
  input logic signed [sle_pkg::WORD_W-1:0] item,
  input logic                              to_positive,
  input logic [sle_pkg::CNT_W-1:0]         count,
  input logic                              last
);
  import sle_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // A split stream that has more words to come keeps the block busy.
  a_stream_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("split stream word without busy");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    strobe |-> count <= CAP_CNT)
    else $error("count beyond capacity");

  a_stream_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> status == STAT_OK)
    else $error("error status inside a stream");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    strobe && status != STAT_OK |-> last && item == '0 && !to_positive)
    else $error("error word carries data");

  a_positive_tag: assert property (@(posedge clk) disable iff (rst)
    strobe && to_positive |-> item > 0)
    else $error("positive tag on a word that is not positive");

endmodule

bind sequential_list_engine_top sle_port_checker #(.CAPACITY(CAPACITY)) u_sle_checker (.*);
